// ===== hdl/e2r_pkg.sv =====
// ----------------------------------------------------------------------------
// e2r_pkg: shared types and constants
// CORDIC angle table in degrees (Q20) and the fixed-point sizes used by the
// Euler-angle to rotation-matrix pipeline.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int unsigned AngW       = 17;
  localparam int unsigned ElemW      = 16;
  localparam int unsigned VecW       = 32;  // Q30 vector plus guard and sign
  localparam int unsigned ZW         = 28;  // residual angle, Q20 degrees
  localparam int unsigned TrigW      = 16;  // Q14 trig value, range +-16384
  localparam int unsigned TabLen     = 24;
  localparam int unsigned CordicStagesDef = 16;
  localparam int          FullTurn   = 46080;
  localparam int          QuarterTurn = 11520;
  localparam logic signed [VecW-1:0] CordicX0 = 32'sd652032875;

  typedef logic [1:0] quad_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [ZW-1:0]   z;
    quad_t                  q;
  } cordic_lane_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int unsigned idx);
    logic signed [ZW-1:0] t;
    t = '0;
    unique case (idx)
      0:  t = 28'sd47185920;
      1:  t = 28'sd27855475;
      2:  t = 28'sd14718068;
      3:  t = 28'sd7471121;
      4:  t = 28'sd3750058;
      5:  t = 28'sd1876857;
      6:  t = 28'sd938658;
      7:  t = 28'sd469357;
      8:  t = 28'sd234682;
      9:  t = 28'sd117342;
      10: t = 28'sd58671;
      11: t = 28'sd29335;
      12: t = 28'sd14668;
      13: t = 28'sd7334;
      14: t = 28'sd3667;
      15: t = 28'sd1833;
      16: t = 28'sd917;
      17: t = 28'sd458;
      18: t = 28'sd229;
      19: t = 28'sd115;
      20: t = 28'sd57;
      21: t = 28'sd29;
      22: t = 28'sd14;
      23: t = 28'sd7;
      default: t = '0;
    endcase
    return t;
  endfunction

  // round Q30 to Q14 and clamp to +-1.0
  function automatic logic signed [TrigW-1:0] q30_to_q14(input logic signed [VecW-1:0] v);
    logic signed [VecW:0] s;
    logic signed [VecW:0] r;
    s = {v[VecW-1], v} + 33'sd32768;
    r = s >>> 16;
    if (r > 33'sd16384)       return 16'sd16384;
    else if (r < -33'sd16384) return -16'sd16384;
    else                      return r[TrigW-1:0];
  endfunction

  // round Q42 to Q14 and saturate
  function automatic logic signed [ElemW-1:0] q42_to_elem(input logic signed [47:0] v);
    logic signed [47:0] s;
    logic signed [47:0] r;
    s = v + (48'sd1 <<< 27);
    r = s >>> 28;
    if (r > 48'sd16384)       return 16'sd16384;
    else if (r < -48'sd16384) return -16'sd16384;
    else                      return r[ElemW-1:0];
  endfunction

endpackage

// ===== hdl/e2r_range_cell.sv =====
// ----------------------------------------------------------------------------
// e2r_range_cell: angle range reduction
// Wraps an angle to [0, 360) degrees and splits it into a quadrant and a
// CORDIC start vector; registered.
// ----------------------------------------------------------------------------
module e2r_range_cell import e2r_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [AngW-1:0] ang_i,
  output cordic_lane_t           lane_o
);

  logic [AngW:0] r0, r1, r2;
  logic [AngW:0] rem;
  quad_t         q;
  cordic_lane_t  lane_d, lane_q;

  always_comb begin
    // -65536..65535 -> [0, 46080): at most two turns to add or remove
    r0 = ang_i[AngW-1] ? 18'($signed({ang_i[AngW-1], ang_i}) + 18'sd92160)
                       : {1'b0, ang_i};
    r1 = (r0 >= 18'(FullTurn)) ? 18'(r0 - 18'(FullTurn)) : r0;
    r2 = (r1 >= 18'(FullTurn)) ? 18'(r1 - 18'(FullTurn)) : r1;
    priority if (r2 >= 18'(3*QuarterTurn)) begin
      q = 2'd3; rem = 18'(r2 - 18'(3*QuarterTurn));
    end else if (r2 >= 18'(2*QuarterTurn)) begin
      q = 2'd2; rem = 18'(r2 - 18'(2*QuarterTurn));
    end else if (r2 >= 18'(QuarterTurn)) begin
      q = 2'd1; rem = 18'(r2 - 18'(QuarterTurn));
    end else begin
      q = 2'd0; rem = r2;
    end
    lane_d.x = CordicX0;
    lane_d.y = '0;
    lane_d.z = $signed({rem[14:0], 13'd0});
    lane_d.q = q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

// ===== hdl/e2r_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// e2r_cordic_cell: one CORDIC rotation stage
// Rotates the vector by +-atan(2^-IDX), driving the residual angle to zero.
// ----------------------------------------------------------------------------
module e2r_cordic_cell import e2r_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  cordic_lane_t lane_i,
  output cordic_lane_t lane_o
);

  cordic_lane_t lane_d, lane_q;
  logic signed [VecW-1:0] dx, dy;

  always_comb begin
    dx = lane_i.y >>> IDX;
    dy = lane_i.x >>> IDX;
    lane_d = lane_i;
    if (!lane_i.z[ZW-1]) begin
      lane_d.x = lane_i.x - dx;
      lane_d.y = lane_i.y + dy;
      lane_d.z = lane_i.z - atan_q20(IDX);
    end else begin
      lane_d.x = lane_i.x + dx;
      lane_d.y = lane_i.y - dy;
      lane_d.z = lane_i.z + atan_q20(IDX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

// ===== hdl/e2r_matrix.sv =====
// ----------------------------------------------------------------------------
// e2r_matrix: rotation matrix from sines and cosines
// Quadrant fix-up and rounding, then two multiply stages and the final
// sum, round and saturate, all registered.
// ----------------------------------------------------------------------------
module e2r_matrix import e2r_pkg::*; (
  input  logic                    clk_i,
  input  logic [3:0]              en_i,
  input  cordic_lane_t            lane_a_i,
  input  cordic_lane_t            lane_h_i,
  input  cordic_lane_t            lane_b_i,
  output logic signed [ElemW-1:0] elem_o [9]
);

  logic signed [TrigW-1:0] trig_d [6];
  logic signed [TrigW-1:0] trig_q [6];   // ca sa ch sh cb sb
  logic signed [31:0]      p2_q [6];     // Q28 pair products
  logic signed [TrigW-1:0] t1_q [3];     // sa, cb, sb delayed
  logic signed [47:0]      p3_q [4];     // Q42 triple products
  logic signed [31:0]      p2b_q [5];    // pair products delayed
  logic signed [31:0]      p2c_q [3];    // ch*sb, sh*cb, ch*cb at the sum stage
  logic signed [ElemW-1:0] elem_q [9];

  function automatic void fix(input cordic_lane_t l,
                              output logic signed [TrigW-1:0] c,
                              output logic signed [TrigW-1:0] s);
    logic signed [VecW-1:0] cq, sq;
    unique case (l.q)
      2'd1:    begin cq = -l.y; sq = l.x;  end
      2'd2:    begin cq = -l.x; sq = -l.y; end
      2'd3:    begin cq = l.y;  sq = -l.x; end
      default: begin cq = l.x;  sq = l.y;  end
    endcase
    c = q30_to_q14(cq);
    s = q30_to_q14(sq);
  endfunction

  always_comb begin
    fix(lane_a_i, trig_d[0], trig_d[1]);
    fix(lane_h_i, trig_d[2], trig_d[3]);
    fix(lane_b_i, trig_d[4], trig_d[5]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) trig_q <= trig_d;
    if (en_i[1]) begin
      p2_q[0] <= trig_q[2] * trig_q[0];  // ch*ca
      p2_q[1] <= trig_q[3] * trig_q[0];  // sh*ca
      p2_q[2] <= trig_q[3] * trig_q[5];  // sh*sb
      p2_q[3] <= trig_q[2] * trig_q[1];  // ch*sa
      p2_q[4] <= trig_q[0] * trig_q[4];  // ca*cb
      p2_q[5] <= trig_q[3] * trig_q[1];  // sh*sa
      t1_q[0] <= trig_q[1];
      t1_q[1] <= trig_q[4];
      t1_q[2] <= trig_q[5];
      p2b_q[0] <= trig_q[2] * trig_q[5]; // ch*sb
      p2b_q[1] <= trig_q[3] * trig_q[4]; // sh*cb
      p2b_q[2] <= trig_q[0] * trig_q[5]; // ca*sb
      p2b_q[3] <= trig_q[2] * trig_q[4]; // ch*cb
    end
    if (en_i[2]) begin
      p3_q[0] <= p2_q[3] * t1_q[1];      // ch*sa*cb
      p3_q[1] <= p2_q[5] * t1_q[1];      // sh*sa*cb
      p3_q[2] <= p2_q[3] * t1_q[2];      // ch*sa*sb
      p3_q[3] <= p2_q[5] * t1_q[2];      // sh*sa*sb
      elem_q[0] <= q42_to_elem(48'(p2_q[0]) <<< 14);
      elem_q[1] <= q42_to_elem(48'(t1_q[0]) <<< 28);
      elem_q[2] <= q42_to_elem(-(48'(p2_q[1]) <<< 14));
      elem_q[4] <= q42_to_elem(48'(p2_q[4]) <<< 14);
      elem_q[7] <= q42_to_elem(-(48'(p2b_q[2]) <<< 14));
      p2b_q[4] <= p2_q[2];
      p2c_q[0] <= p2b_q[0];
      p2c_q[1] <= p2b_q[1];
      p2c_q[2] <= p2b_q[3];
    end
    if (en_i[3]) begin
      elem_o[0] <= elem_q[0];
      elem_o[1] <= elem_q[1];
      elem_o[2] <= elem_q[2];
      elem_o[4] <= elem_q[4];
      elem_o[7] <= elem_q[7];
      elem_o[3] <= q42_to_elem((48'(p2b_q[4]) <<< 14) - p3_q[0]);
      elem_o[5] <= q42_to_elem(p3_q[1] + (48'(p2c_q[0]) <<< 14));
      elem_o[6] <= q42_to_elem(p3_q[2] + (48'(p2c_q[1]) <<< 14));
      elem_o[8] <= q42_to_elem((48'(p2c_q[2]) <<< 14) - p3_q[3]);
    end
  end

endmodule

// ===== hdl/euler_to_rotation_matrix.sv =====
// Throughput: one item per cycle; each pipeline register advances whenever
// its successor is free, so a stall backs up stage by stage.
// Reset clears the valid bits only; data registers are not reset.
// The CORDIC chain of min(CORDIC_STAGES, TabLen) cells sets the latency.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix: Euler angles to 3x3 rotation matrix
// Three CORDIC cell chains produce sine and cosine; the matrix stages form
// the nine Q1.14 matrix elements.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix import e2r_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [AngW-1:0]  attitude_deg_i,
  input  logic signed [AngW-1:0]  heading_deg_i,
  input  logic signed [AngW-1:0]  bank_deg_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [ElemW-1:0] elem_0_o,
  output logic signed [ElemW-1:0] elem_1_o,
  output logic signed [ElemW-1:0] elem_2_o,
  output logic signed [ElemW-1:0] elem_3_o,
  output logic signed [ElemW-1:0] elem_4_o,
  output logic signed [ElemW-1:0] elem_5_o,
  output logic signed [ElemW-1:0] elem_6_o,
  output logic signed [ElemW-1:0] elem_7_o,
  output logic signed [ElemW-1:0] elem_8_o
);

  localparam int unsigned NCord = (CORDIC_STAGES < TabLen) ? CORDIC_STAGES : TabLen;
  localparam int unsigned NStg  = NCord + 5;  // range, cordic, 4 matrix stages

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;
  cordic_lane_t    lane [3][NCord+1];
  logic signed [ElemW-1:0] elem [9];

  // stage k may load when it is empty or its content moves on
  always_comb begin
    en[NStg-1] = !vld_q[NStg-1] || ready_i;
    for (int k = NStg-2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NStg; k++) if (en[k]) vld_q[k] <= vld_q[k-1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[NStg-1];

  e2r_range_cell u_rng_a (.clk_i, .en_i(en[0]), .ang_i(attitude_deg_i), .lane_o(lane[0][0]));
  e2r_range_cell u_rng_h (.clk_i, .en_i(en[0]), .ang_i(heading_deg_i),  .lane_o(lane[1][0]));
  e2r_range_cell u_rng_b (.clk_i, .en_i(en[0]), .ang_i(bank_deg_i),     .lane_o(lane[2][0]));

  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar i = 0; i < NCord; i++) begin : g_cell
      e2r_cordic_cell #(.IDX(i)) u_cell (
        .clk_i, .en_i(en[i+1]), .lane_i(lane[a][i]), .lane_o(lane[a][i+1])
      );
    end
  end

  e2r_matrix u_mat (
    .clk_i,
    .en_i    (en[NStg-1:NCord+1]),
    .lane_a_i(lane[0][NCord]),
    .lane_h_i(lane[1][NCord]),
    .lane_b_i(lane[2][NCord]),
    .elem_o  (elem)
  );

  assign elem_0_o = elem[0];
  assign elem_1_o = elem[1];
  assign elem_2_o = elem[2];
  assign elem_3_o = elem[3];
  assign elem_4_o = elem[4];
  assign elem_5_o = elem[5];
  assign elem_6_o = elem[6];
  assign elem_7_o = elem[7];
  assign elem_8_o = elem[8];

endmodule

// ===== hdl/e2r_checker.sv =====
// ----------------------------------------------------------------------------
// e2r_checker: port-level checks
// Handshake stability and matrix element range.
// ----------------------------------------------------------------------------
module e2r_checker import e2r_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    valid_o,
  input logic                    ready_i,
  input logic signed [ElemW-1:0] elem_0_o,
  input logic signed [ElemW-1:0] elem_1_o,
  input logic signed [ElemW-1:0] elem_4_o
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o) else $error("valid_o dropped");

  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (elem_0_o <= 16'sd16384 && elem_0_o >= -16'sd16384 &&
                 elem_4_o <= 16'sd16384 && elem_4_o >= -16'sd16384))
    else $error("element out of range");

  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (elem_1_o <= 16'sd16384 && elem_1_o >= -16'sd16384))
    else $error("sin out of range");

endmodule

bind euler_to_rotation_matrix e2r_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .ready_i, .elem_0_o, .elem_1_o, .elem_4_o
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: euler_to_rotation_matrix testbench
// Drives angle triples through the valid/ready input, predicts the nine
// matrix elements with a bit-exact CORDIC model and checks every transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
  logic signed [15:0] e [9];
} matrix_t;

class matrix_scoreboard;
  matrix_t pending[$];
  int      errors;
  int      checked;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab [24];
    tab = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
            938658, 469357, 234682, 117342, 58671, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    return tab[i];
  endfunction

  function automatic void sin_cos(logic signed [16:0] ang, output longint c,
                                  output longint s);
    longint r, q, z, x, y, dx, dy, cq, sq;
    r = longint'(ang) % 46080;
    if (r < 0) r += 46080;
    q = r / 11520;
    z = (r % 11520) * 8192;
    x = 652032875;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    case (q)
      1: begin cq = -y; sq = x; end
      2: begin cq = -x; sq = -y; end
      3: begin cq = y; sq = -x; end
      default: begin cq = x; sq = y; end
    endcase
    c = clamp_unit(floor_shr(cq + 32768, 16));
    s = clamp_unit(floor_shr(sq + 32768, 16));
  endfunction

  function automatic logic signed [15:0] q42_round(longint v);
    return 16'(clamp_unit(floor_shr(v + (longint'(1) << 27), 28)));
  endfunction

  function void note_angles(logic signed [16:0] a, logic signed [16:0] h,
                            logic signed [16:0] b);
    longint ca, sa, ch, sh, cb, sb;
    matrix_t m;
    sin_cos(a, ca, sa);
    sin_cos(h, ch, sh);
    sin_cos(b, cb, sb);
    m.e[0] = q42_round(ch * ca * 16384);
    m.e[1] = q42_round(sa * 16384 * 16384);
    m.e[2] = q42_round(-sh * ca * 16384);
    m.e[3] = q42_round(sh * sb * 16384 - ch * sa * cb);
    m.e[4] = q42_round(ca * cb * 16384);
    m.e[5] = q42_round(sh * sa * cb + ch * sb * 16384);
    m.e[6] = q42_round(ch * sa * sb + sh * cb * 16384);
    m.e[7] = q42_round(-ca * sb * 16384);
    m.e[8] = q42_round(-sh * sa * sb + ch * cb * 16384);
    pending.push_back(m);
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endfunction

  function void check_matrix(matrix_t got);
    matrix_t want;
    checked++;
    if (pending.size() == 0) begin
      report("result transfer with nothing pending");
      return;
    end
    want = pending.pop_front();
    for (int i = 0; i < 9; i++)
      if (got.e[i] !== want.e[i])
        report($sformatf("item %0d elem_%0d got %0d want %0d",
                         checked - 1, i, got.e[i], want.e[i]));
  endfunction
endclass

module tb;
  import e2r_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_i = 1'b0;
  logic signed [AngW-1:0] attitude_deg_i = '0;
  logic signed [AngW-1:0] heading_deg_i = '0;
  logic signed [AngW-1:0] bank_deg_i = '0;
  logic ready_o, valid_o;
  logic signed [ElemW-1:0] elem_0_o, elem_1_o, elem_2_o, elem_3_o, elem_4_o;
  logic signed [ElemW-1:0] elem_5_o, elem_6_o, elem_7_o, elem_8_o;

  matrix_scoreboard sb = new();
  bit  sending_done = 0;
  int  sent = 0;
  int  idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  euler_to_rotation_matrix dut (.*);

  function automatic logic signed [16:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 17'($urandom);                         // any pattern, wraps
      1: return 17'(11520 * $signed($urandom_range(0, 8)) - 46080);
      2: return 17'(11520 * $signed($urandom_range(0, 8)) - 46080
                    + $signed($urandom_range(0, 4)) - 2);
      default: return 17'($signed($urandom_range(0, 92160)) - 46080);
    endcase
  endfunction

  task automatic send_angles(logic signed [16:0] a, logic signed [16:0] h,
                             logic signed [16:0] b, int gap);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    attitude_deg_i <= a;
    heading_deg_i <= h;
    bank_deg_i <= b;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    sb.note_angles(a, h, b);
    sent++;
  endtask

  // sender
  initial begin
    logic signed [16:0] corner [10];
    corner = '{17'sd0, 17'sd46080, -17'sd46080, 17'sd11520, -17'sd11520,
               17'sd23040, 17'sd34560, 17'sd65535, 17'sh10000, 17'sd1};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (corner[i]) begin
      send_angles(corner[i], 17'sd0, 17'sd0, 0);
      send_angles(17'sd0, corner[i], corner[(i + 3) % 10], 0);
    end
    send_angles(17'sd5760, -17'sd5760, 17'sd46079, 0);
    for (int n = 0; n < 1200; n++) begin
      if (n >= 300 && n < 500) send_angles(rand_angle(), rand_angle(), rand_angle(), 0);
      else send_angles(rand_angle(), rand_angle(), rand_angle(), $urandom_range(0, 6));
    end
    valid_i <= 1'b0;
    sending_done = 1;
  end

  // receiver; one long hold-off while the sender keeps offering
  initial begin
    int stall;
    int transfers;
    transfers = 0;
    @(posedge rst_ni);
    forever begin
      if (transfers == 320) stall = 200;
      else if (transfers > 600 && transfers < 800) stall = 0;
      else stall = $urandom_range(0, 6);
      if (stall > 0) begin
        ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ready_i <= 1'b1;
      @(posedge clk_i);
      while (!valid_o) @(posedge clk_i);
      transfers++;
    end
  end

  // sample outputs at the edge
  always @(posedge clk_i) begin
    matrix_t got;
    if (rst_ni && valid_o && ready_i) begin
      got.e = '{elem_0_o, elem_1_o, elem_2_o, elem_3_o, elem_4_o,
                elem_5_o, elem_6_o, elem_7_o, elem_8_o};
      sb.check_matrix(got);
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("watchdog expired, %0d results outstanding", sb.pending.size());
      $display("euler_to_rotation_matrix test failed");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    wait (sb.pending.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("sent %0d angle triples, checked %0d matrices", sent, sb.checked);
    $display("covered quadrant edges, wraparound patterns and backpressure stalls");
    if (sb.errors == 0) $display("euler_to_rotation_matrix test passed");
    else $display("euler_to_rotation_matrix test failed");
    $finish;
  end
endmodule
